[hw/rtl/ordered_timer_queue_defines.svh]
// Assertion macros used by the timer queue controller.
// Depends on nothing; users must provide clk and rst_n in scope.
`ifndef ORDERED_TIMER_QUEUE_DEFINES_SVH
`define ORDERED_TIMER_QUEUE_DEFINES_SVH

// same-cycle implication
`define OTQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/otq_pkg.sv]
// Types and constants for the ordered timer queue.
// No dependencies; imported by otq_ctrl and the top level.
`default_nettype none

package otq_pkg;

    localparam int TIMER_SLOTS_DEF = 16;
    localparam int TIME_W          = 48;
    localparam int IVL_W           = 32;
    localparam int HANDLE_W        = 4;
    localparam int CFG_W           = 16;

    localparam logic [CFG_W-1:0] MIN_ARM_DELAY_RST = 16'd100;

    typedef enum logic {
        ACT_ADD  = 1'b0,
        ACT_TICK = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        KIND_ADD_OK   = 2'd0,
        KIND_ADD_FULL = 2'd1,
        KIND_FIRED    = 2'd2,
        KIND_SUMMARY  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_FIRE_SCAN,
        ST_FIRE_EMIT,
        ST_REARM,
        ST_SUMMARY
    } state_t;

    typedef struct packed {
        kind_t                kind;
        logic [HANDLE_W-1:0]  handle;
        logic [TIME_W-1:0]    fire_dl;
        logic                 changed;
        logic                 nvalid;
        logic [TIME_W-1:0]    next_dl;
        logic [TIME_W-1:0]    delay;
        logic                 last;
    } res_t;

endpackage

`default_nettype wire

[hw/rtl/otq_ram.sv]
// Simple dual-port RAM, one write and one registered read port.
// Depends on nothing.
`default_nettype none

module otq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_array[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hw/rtl/otq_ctrl.sv]
// Sequencer of the timer queue: slot bookkeeping, scan passes, result words.
// Depends on otq_pkg, ordered_timer_queue_defines.svh and the two slot RAMs at the top level.
`default_nettype none

`include "ordered_timer_queue_defines.svh"

module otq_ctrl import otq_pkg::*; #(
    parameter int TIMER_SLOTS = TIMER_SLOTS_DEF,
    localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1,
    localparam int CNT_W = $clog2(TIMER_SLOTS + 1)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_go,
    input  wire logic              in_action,
    input  wire logic [TIME_W-1:0] in_time,
    input  wire logic [IVL_W-1:0]  in_ivl,
    output logic                   busy,
    input  wire logic [CFG_W-1:0]  min_arm_delay,
    output res_t                   res,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output logic [IDX_W-1:0]       mem_raddr,
    output logic [IDX_W-1:0]       mem_waddr,
    output logic                   dl_we,
    output logic [TIME_W-1:0]      dl_wdata,
    input  wire logic [TIME_W-1:0] dl_rdata,
    output logic                   iv_we,
    output logic [IVL_W-1:0]       iv_wdata,
    input  wire logic [IVL_W-1:0]  iv_rdata
);

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    p_vld_reg, p_vld_next;
    logic [IDX_W-1:0]        p_idx_reg, p_idx_next;
    logic [TIME_W-1:0]       t_reg, t_next;
    logic [IVL_W-1:0]        ivl_reg, ivl_next;
    logic [TIMER_SLOTS-1:0]  used_reg, used_next;
    logic [TIMER_SLOTS-1:0]  fired_reg, fired_next;
    logic                    best_vld_reg, best_vld_next;
    logic [IDX_W-1:0]        best_idx_reg, best_idx_next;
    logic [TIME_W-1:0]       best_dl_reg, best_dl_next;
    logic                    min_vld_reg, min_vld_next;
    logic [TIME_W-1:0]       min_dl_reg, min_dl_next;

    logic                    full;
    logic [IDX_W-1:0]        free_idx;
    logic                    scan_done;
    logic                    p_used;
    logic                    p_fired;
    logic [TIME_W:0]         rearm_sum;
    logic [TIME_W-1:0]       rearm_dl;
    logic [TIME_W:0]         diff_full;
    logic [TIME_W-1:0]       diff;
    logic [TIME_W-1:0]       floor_dl;
    logic [TIME_W-1:0]       arm_dl;
    logic                    changed;
    logic [HANDLE_W+IDX_W-1:0] hext_free;
    logic [HANDLE_W+IDX_W-1:0] hext_best;

    // lowest free slot
    always_comb
    begin
        full     = &used_reg;
        free_idx = '0;
        for (int i = TIMER_SLOTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign scan_done = (cnt_reg == CNT_W'(TIMER_SLOTS)) && !p_vld_reg;
    assign p_used    = used_reg[p_idx_reg];
    assign p_fired   = fired_reg[p_idx_reg];

    // re-arm at now + interval, saturating
    assign rearm_sum = {1'b0, t_reg} + (TIME_W + 1)'(iv_rdata);
    assign rearm_dl  = rearm_sum[TIME_W] ? '1 : rearm_sum[TIME_W-1:0];

    assign diff_full = {1'b0, min_dl_reg} - {1'b0, t_reg};
    assign diff      = diff_full[TIME_W] ? '0 : diff_full[TIME_W-1:0];
    assign floor_dl  = TIME_W'(min_arm_delay);
    assign arm_dl    = (diff < floor_dl) ? floor_dl : diff;

    assign changed   = !min_vld_reg || (t_reg < min_dl_reg);
    assign hext_free = {HANDLE_W'(0), free_idx};
    assign hext_best = {HANDLE_W'(0), best_idx_reg};

    assign busy      = (state_reg != ST_IDLE);
    assign mem_raddr = cnt_reg[IDX_W-1:0];
    assign iv_wdata  = ivl_reg;

    always_comb
    begin
        logic              cand;
        logic [TIME_W-1:0] cand_dl;

        cand          = 1'b0;
        cand_dl       = '0;
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        p_vld_next    = 1'b0;
        p_idx_next    = cnt_reg[IDX_W-1:0];
        t_next        = t_reg;
        ivl_next      = ivl_reg;
        used_next     = used_reg;
        fired_next    = fired_reg;
        best_vld_next = best_vld_reg;
        best_idx_next = best_idx_reg;
        best_dl_next  = best_dl_reg;
        min_vld_next  = min_vld_reg;
        min_dl_next   = min_dl_reg;
        res           = '0;
        res_valid     = 1'b0;
        mem_waddr     = free_idx;
        dl_we         = 1'b0;
        dl_wdata      = t_reg;
        iv_we         = 1'b0;

        // read issue shared by both scan passes
        if ((state_reg == ST_FIRE_SCAN || state_reg == ST_REARM)
            && cnt_reg < CNT_W'(TIMER_SLOTS))
        begin
            p_vld_next = 1'b1;
            cnt_next   = cnt_reg + 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_go)
                begin
                    t_next   = in_time;
                    ivl_next = in_ivl;
                    if (in_action == ACT_TICK)
                    begin
                        cnt_next      = '0;
                        best_vld_next = 1'b0;
                        state_next    = ST_FIRE_SCAN;
                    end
                    else
                    begin
                        state_next = ST_ADD;
                    end
                end
            end

            ST_ADD:
            begin
                res_valid = 1'b1;
                res.last  = 1'b1;
                if (full)
                begin
                    res.kind    = KIND_ADD_FULL;
                    res.nvalid  = min_vld_reg;
                    res.next_dl = min_vld_reg ? min_dl_reg : '0;
                end
                else
                begin
                    res.kind    = KIND_ADD_OK;
                    res.handle  = hext_free[HANDLE_W-1:0];
                    res.changed = changed;
                    res.nvalid  = 1'b1;
                    res.next_dl = changed ? t_reg : min_dl_reg;
                end
                if (res_ready)
                begin
                    if (!full)
                    begin
                        dl_we               = 1'b1;
                        iv_we               = 1'b1;
                        used_next[free_idx] = 1'b1;
                        min_vld_next        = 1'b1;
                        min_dl_next         = changed ? t_reg : min_dl_reg;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_FIRE_SCAN:
            begin
                // earliest unfired expired slot; strict compare keeps lower handle on ties
                if (p_vld_reg && p_used && !p_fired && dl_rdata <= t_reg
                    && (!best_vld_reg || dl_rdata < best_dl_reg))
                begin
                    best_vld_next = 1'b1;
                    best_idx_next = p_idx_reg;
                    best_dl_next  = dl_rdata;
                end
                if (scan_done)
                begin
                    cnt_next = '0;
                    if (best_vld_reg)
                    begin
                        state_next = ST_FIRE_EMIT;
                    end
                    else
                    begin
                        min_vld_next = 1'b0;
                        state_next   = ST_REARM;
                    end
                end
            end

            ST_FIRE_EMIT:
            begin
                res_valid   = 1'b1;
                res.kind    = KIND_FIRED;
                res.handle  = hext_best[HANDLE_W-1:0];
                res.fire_dl = best_dl_reg;
                if (res_ready)
                begin
                    fired_next[best_idx_reg] = 1'b1;
                    best_vld_next            = 1'b0;
                    cnt_next                 = '0;
                    state_next               = ST_FIRE_SCAN;
                end
            end

            ST_REARM:
            begin
                // write lags read by one slot, so no same-entry overlap
                if (p_vld_reg)
                begin
                    if (p_fired)
                    begin
                        if (iv_rdata != '0)
                        begin
                            dl_we     = 1'b1;
                            mem_waddr = p_idx_reg;
                            dl_wdata  = rearm_dl;
                            cand      = 1'b1;
                            cand_dl   = rearm_dl;
                        end
                        else
                        begin
                            used_next[p_idx_reg] = 1'b0;
                        end
                    end
                    else if (p_used)
                    begin
                        cand    = 1'b1;
                        cand_dl = dl_rdata;
                    end
                end
                if (cand && (!min_vld_reg || cand_dl < min_dl_reg))
                begin
                    min_vld_next = 1'b1;
                    min_dl_next  = cand_dl;
                end
                if (scan_done)
                begin
                    state_next = ST_SUMMARY;
                end
            end

            ST_SUMMARY:
            begin
                res_valid   = 1'b1;
                res.kind    = KIND_SUMMARY;
                res.nvalid  = min_vld_reg;
                res.next_dl = min_vld_reg ? min_dl_reg : '0;
                res.delay   = min_vld_reg ? arm_dl : '0;
                res.last    = 1'b1;
                if (res_ready)
                begin
                    fired_next = '0;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            p_vld_reg    <= 1'b0;
            used_reg     <= '0;
            fired_reg    <= '0;
            best_vld_reg <= 1'b0;
            min_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            p_vld_reg    <= p_vld_next;
            used_reg     <= used_next;
            fired_reg    <= fired_next;
            best_vld_reg <= best_vld_next;
            min_vld_reg  <= min_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_idx_reg    <= p_idx_next;
        t_reg        <= t_next;
        ivl_reg      <= ivl_next;
        best_idx_reg <= best_idx_next;
        best_dl_reg  <= best_dl_next;
        min_dl_reg   <= min_dl_next;
    end

    `OTQ_ASSERT_NOW(a_emit_has_pick, state_reg == ST_FIRE_EMIT, best_vld_reg, "fire without a pick")
    `OTQ_ASSERT_NOW(a_no_refire, state_reg == ST_FIRE_EMIT, !fired_reg[best_idx_reg], "slot fired twice")
    `OTQ_ASSERT_NOW(a_idle_clean, state_reg == ST_IDLE, (fired_reg == '0) && (min_vld_reg == (|used_reg)), "stale tick state in idle")
    `OTQ_ASSERT_NOW(a_rearm_no_overlap, (state_reg == ST_REARM) && dl_we, mem_raddr != mem_waddr, "read/write overlap in re-arm")
    `OTQ_ASSERT_NEXT(a_emit_rescan, (state_reg == ST_FIRE_EMIT) && res_ready, (state_reg == ST_FIRE_SCAN) && (cnt_reg == '0), "no rescan after fire")

endmodule

`default_nettype wire

[hw/rtl/ordered_timer_queue.sv]
// Ordered timer queue top level: config register, output register, slot RAMs.
// Depends on otq_pkg, otq_ram and otq_ctrl.
//
// Input channel (in_valid/in_stall): action 0 adds a timer with deadline
// event_time and period repeat_interval; action 1 is a tick at time event_time.
// Output channel (out_valid/out_stall): one word per add (handle, earliest
// changed, next deadline), and for a tick one word per expired timer in
// deadline order followed by a summary word with next deadline and arm delay.
// last marks the final word of an item. cfg_valid/cfg_ready writes
// min_arm_delay; cfg_ready is always high.
// Sequence: an add moves from idle to the add state, which emits its word. A
// tick runs one read pass over all slots per fired timer plus one more, then a
// re-arm pass over all slots. The single read port of the slot RAMs makes each
// pass read the slots one at a time. One item is in work at a time; in_stall
// is high while it runs. Results sit in an output register, so the next item
// is accepted while the last word waits on out_stall; a stalled receiver
// holds the block. Reset frees every slot and sets min_arm_delay to 100; no
// clearing pass.
`default_nettype none

module ordered_timer_queue import otq_pkg::*; #(
    parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              action,
    input  wire logic [TIME_W-1:0] event_time,
    input  wire logic [IVL_W-1:0]  repeat_interval,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [1:0]             kind,
    output logic [HANDLE_W-1:0]    timer_handle,
    output logic [TIME_W-1:0]      fire_deadline,
    output logic                   earliest_changed,
    output logic                   next_valid,
    output logic [TIME_W-1:0]      next_deadline,
    output logic [TIME_W-1:0]      arm_delay,
    output logic                   last,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CFG_W-1:0]  cfg_data
);

    localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

    logic [CFG_W-1:0]  min_arm_delay_reg, min_arm_delay_next;
    logic              out_valid_reg, out_valid_next;
    res_t              out_res_reg;
    res_t              res;
    logic              res_valid;
    logic              res_ready;
    logic              busy;
    logic              in_go;
    logic [IDX_W-1:0]  mem_raddr;
    logic [IDX_W-1:0]  mem_waddr;
    logic              dl_we;
    logic [TIME_W-1:0] dl_wdata;
    logic [TIME_W-1:0] dl_rdata;
    logic              iv_we;
    logic [IVL_W-1:0]  iv_wdata;
    logic [IVL_W-1:0]  iv_rdata;

    assign in_stall  = busy;
    assign in_go     = in_valid && !busy;
    assign cfg_ready = 1'b1;
    assign res_ready = !out_valid_reg || !out_stall;

    always_comb
    begin
        min_arm_delay_next = min_arm_delay_reg;
        if (cfg_valid && cfg_ready)
        begin
            min_arm_delay_next = cfg_data;
        end
        out_valid_next = out_valid_reg && out_stall;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_arm_delay_reg <= MIN_ARM_DELAY_RST;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            min_arm_delay_reg <= min_arm_delay_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid        = out_valid_reg;
    assign kind             = out_res_reg.kind;
    assign timer_handle     = out_res_reg.handle;
    assign fire_deadline    = out_res_reg.fire_dl;
    assign earliest_changed = out_res_reg.changed;
    assign next_valid       = out_res_reg.nvalid;
    assign next_deadline    = out_res_reg.next_dl;
    assign arm_delay        = out_res_reg.delay;
    assign last             = out_res_reg.last;

    otq_ram #(
        .WIDTH (TIME_W),
        .DEPTH (TIMER_SLOTS)
    ) u_dl_ram (
        .clk   (clk),
        .we    (dl_we),
        .waddr (mem_waddr),
        .wdata (dl_wdata),
        .raddr (mem_raddr),
        .rdata (dl_rdata)
    );

    otq_ram #(
        .WIDTH (IVL_W),
        .DEPTH (TIMER_SLOTS)
    ) u_iv_ram (
        .clk   (clk),
        .we    (iv_we),
        .waddr (mem_waddr),
        .wdata (iv_wdata),
        .raddr (mem_raddr),
        .rdata (iv_rdata)
    );

    otq_ctrl #(
        .TIMER_SLOTS (TIMER_SLOTS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_go         (in_go),
        .in_action     (action),
        .in_time       (event_time),
        .in_ivl        (repeat_interval),
        .busy          (busy),
        .min_arm_delay (min_arm_delay_reg),
        .res           (res),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .mem_raddr     (mem_raddr),
        .mem_waddr     (mem_waddr),
        .dl_we         (dl_we),
        .dl_wdata      (dl_wdata),
        .dl_rdata      (dl_rdata),
        .iv_we         (iv_we),
        .iv_wdata      (iv_wdata),
        .iv_rdata      (iv_rdata)
    );

endmodule

`default_nettype wire
